// ----- rtl/bitmap_line_rasterizer_top_assert.svh -----
// Assertion macros for the line rasterizer; clocked on clk, quiet during rst.
`ifndef BITMAP_LINE_RASTERIZER_TOP_ASSERT_SVH
`define BITMAP_LINE_RASTERIZER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the trigger.
`define BLR_ASSERT_NOW(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("blr check failed");

// Consequent must hold in the cycle after the trigger.
`define BLR_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("blr check failed");

`endif

// ----- rtl/blr_pkg.sv -----
package blr_pkg;

  localparam int unsigned COORD_W = 8;
  localparam int unsigned ERR_W   = 9;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Register index (paddr[2])
  localparam logic REG_BASE_PAGE = 1'b0;

  localparam logic       REQ_START = 1'b0;
  localparam logic       REQ_STEP  = 1'b1;

  localparam logic [7:0] BASE_PAGE_RESET = 8'd32;
  localparam logic [7:0] MASK_MSB        = 8'h80;
  localparam logic [7:0] CELL_X_MASK     = 8'hF8;

  // Pixel moving from the stepper to the address stage
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } pix_t;

  // Stepper status seen by the top level
  typedef struct packed {
    logic line_active;
    logic pix_valid;
  } step_status_t;

endpackage

// ----- rtl/blr_cfg.sv -----
module blr_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [blr_pkg::PADDR_W-1:0] paddr,
  input  logic [blr_pkg::PDATA_W-1:0] pwdata,
  output logic [blr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [7:0]                  base_page
);
  import blr_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_page <= BASE_PAGE_RESET;
    end else if (wr_en && (paddr[2] == REG_BASE_PAGE)) begin
      base_page <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_BASE_PAGE) begin
      prdata = {{(PDATA_W-8){1'b0}}, base_page};
    end
  end

endmodule

// ----- rtl/blr_stepper.sv -----
module blr_stepper (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic                 req_type,
  input  logic [7:0]           start_x,
  input  logic [7:0]           start_y,
  input  logic [7:0]           end_x,
  input  logic [7:0]           end_y,
  input  logic                 take,
  output blr_pkg::pix_t        pix,
  output blr_pkg::step_status_t status
);
  import blr_pkg::*;

  logic [COORD_W-1:0] cur_x, cur_y, major_end, major_delta, minor_delta;
  logic [ERR_W-1:0]   error_acc;
  logic               x_is_major, minor_decrements, line_active;
  logic               pix_valid;

  logic [COORD_W-1:0] cur_x_next, cur_y_next, major_end_next;
  logic [COORD_W-1:0] major_delta_next, minor_delta_next;
  logic [ERR_W-1:0]   error_acc_next;
  logic               x_is_major_next, minor_decrements_next;

  logic               accept, emit, fin;
  logic               xinc, yinc, bump;
  logic [COORD_W-1:0] xd, yd, minor_stepped;
  logic [ERR_W-1:0]   err_sum;

  assign req_stall = pix_valid && !take;
  assign accept    = req_valid && !req_stall;
  assign emit      = accept && ((req_type == REQ_START) || line_active);

  always_comb begin
    xinc = start_x < end_x;
    yinc = start_y < end_y;
    xd   = xinc ? (end_x - start_x) : (start_x - end_x);
    yd   = yinc ? (end_y - start_y) : (start_y - end_y);

    err_sum       = error_acc + {1'b0, minor_delta};
    bump          = {1'b0, major_delta} < err_sum;
    minor_stepped = '0;

    cur_x_next            = cur_x;
    cur_y_next            = cur_y;
    major_end_next        = major_end;
    major_delta_next      = major_delta;
    minor_delta_next      = minor_delta;
    error_acc_next        = error_acc;
    x_is_major_next       = x_is_major;
    minor_decrements_next = minor_decrements;

    if (req_type == REQ_START) begin
      x_is_major_next       = yd < xd;
      minor_decrements_next = xinc != yinc;
      if (yd < xd) begin
        major_delta_next = xd;
        minor_delta_next = yd;
        cur_x_next       = xinc ? start_x : end_x;
        cur_y_next       = xinc ? start_y : end_y;
        major_end_next   = xinc ? end_x : start_x;
      end else begin
        major_delta_next = yd;
        minor_delta_next = xd;
        cur_x_next       = yinc ? start_x : end_x;
        cur_y_next       = yinc ? start_y : end_y;
        major_end_next   = yinc ? end_y : start_y;
      end
      error_acc_next = {2'b00, minor_delta_next[7:1]};
    end else begin
      error_acc_next = bump ? (err_sum - {1'b0, major_delta}) : err_sum;
      if (x_is_major) begin
        minor_stepped = minor_decrements ? (cur_y - 8'd1) : (cur_y + 8'd1);
        cur_x_next    = cur_x + 8'd1;
        cur_y_next    = bump ? minor_stepped : cur_y;
      end else begin
        minor_stepped = minor_decrements ? (cur_x - 8'd1) : (cur_x + 8'd1);
        cur_y_next    = cur_y + 8'd1;
        cur_x_next    = bump ? minor_stepped : cur_x;
      end
    end

    fin = (x_is_major_next ? cur_x_next : cur_y_next) == major_end_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x            <= '0;
      cur_y            <= '0;
      major_end        <= '0;
      major_delta      <= '0;
      minor_delta      <= '0;
      error_acc        <= '0;
      x_is_major       <= 1'b0;
      minor_decrements <= 1'b0;
      line_active      <= 1'b0;
    end else if (emit) begin
      cur_x            <= cur_x_next;
      cur_y            <= cur_y_next;
      major_end        <= major_end_next;
      major_delta      <= major_delta_next;
      minor_delta      <= minor_delta_next;
      error_acc        <= error_acc_next;
      x_is_major       <= x_is_major_next;
      minor_decrements <= minor_decrements_next;
      line_active      <= !fin;
    end
  end

  // Pixel stage register: load on every free slot, drop a step with no line
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (!req_stall) begin
      pix_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pix.x    <= cur_x_next;
      pix.y    <= cur_y_next;
      pix.last <= fin;
    end
  end

  assign status.line_active = line_active;
  assign status.pix_valid   = pix_valid;

endmodule

// ----- rtl/blr_addr.sv -----
module blr_addr (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pix_in_valid,
  input  blr_pkg::pix_t             pix,
  input  logic [7:0]                base_page,
  output logic                      take,
  output logic                      valid,
  input  logic                      stall,
  output logic [blr_pkg::ADDR_W-1:0] byte_addr,
  output logic [7:0]                bit_mask,
  output logic [7:0]                pixel_x,
  output logic [7:0]                pixel_y,
  output logic                      last
);
  import blr_pkg::*;

  logic [ADDR_W-1:0] addr_next;
  logic [4:0]        cell_row;

  assign take = !valid || !stall;

  // row * 320 = row * 256 + row * 64
  always_comb begin
    cell_row  = pix.y[7:3];
    addr_next = {base_page, 8'h00}
              + {8'h00, pix.x & CELL_X_MASK}
              + {3'b000, cell_row, 8'h00}
              + {5'b00000, cell_row, 6'b000000}
              + {13'd0, pix.y[2:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= pix_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && pix_in_valid) begin
      byte_addr <= addr_next;
      bit_mask  <= MASK_MSB >> pix.x[2:0];
      pixel_x   <= pix.x;
      pixel_y   <= pix.y;
      last      <= pix.last;
    end
  end

endmodule

// ----- rtl/bitmap_line_rasterizer_top.sv -----
// Bresenham line stepper for a bitmap of 8x8-pixel cells, 320 bytes per cell row.
// Request channel (req_valid/req_stall): req_type 0 starts a line from
//   start_x/start_y to end_x/end_y and emits its first pixel; req_type 1
//   advances one pixel. A step with no line in progress gives no result.
// Result channel (pix_valid/pix_stall): byte_addr, bit_mask (OR into the
//   byte), pixel_x, pixel_y and last, set on the line's final endpoint.
// Config port: APB write to offset 0 sets base_page (reset 32).
//   Write it only while no request is in flight.
// Path: a taken request loads the pixel register, then the address/output
//   register, which drives pix_valid; a stall can hold it between the two.
// Throughput: one request per cycle while req_stall is low; the error add,
//   compare and coordinate update of a step are combinational, so steps chain.
// A stalled result holds; the pixel register still takes one more request,
//   after which req_stall follows pix_stall.
// Reset clears the line state, drops any queued pixel and restores the
//   base page to 32.
module bitmap_line_rasterizer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [blr_pkg::PADDR_W-1:0]   paddr,
  input  logic [blr_pkg::PDATA_W-1:0]   pwdata,
  output logic [blr_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          req_type,
  input  logic [7:0]                    start_x,
  input  logic [7:0]                    start_y,
  input  logic [7:0]                    end_x,
  input  logic [7:0]                    end_y,
  output logic                          pix_valid,
  input  logic                          pix_stall,
  output logic [blr_pkg::ADDR_W-1:0]    byte_addr,
  output logic [7:0]                    bit_mask,
  output logic [7:0]                    pixel_x,
  output logic [7:0]                    pixel_y,
  output logic                          last
);
  import blr_pkg::*;

  `include "bitmap_line_rasterizer_top_assert.svh"

  logic         [7:0] base_page;
  logic               take;
  pix_t               pix;
  step_status_t       status;
  logic               req_accept;
  logic               step_idle;
  logic               start_take;

  blr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .base_page (base_page)
  );

  blr_stepper u_stepper (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .take      (take),
    .pix       (pix),
    .status    (status)
  );

  blr_addr u_addr (
    .clk          (clk),
    .rst          (rst),
    .pix_in_valid (status.pix_valid),
    .pix          (pix),
    .base_page    (base_page),
    .take         (take),
    .valid        (pix_valid),
    .stall        (pix_stall),
    .byte_addr    (byte_addr),
    .bit_mask     (bit_mask),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .last         (last)
  );

  assign req_accept = req_valid && !req_stall;
  assign step_idle  = req_accept && req_type == REQ_STEP && !status.line_active;
  assign start_take = req_accept && req_type == REQ_START;

  `BLR_ASSERT_NEXT(a_step_idle_drops, step_idle, !status.pix_valid)
  `BLR_ASSERT_NEXT(a_start_emits, start_take, status.pix_valid && status.line_active != pix.last)
  `BLR_ASSERT_NOW(a_mask_onehot, pix_valid, $onehot(bit_mask))
  `BLR_ASSERT_NOW(a_stall_only_full, req_stall, status.pix_valid && pix_valid && pix_stall)

endmodule
